// File: hdl/frequency_ordered_list_macros.svh
// Assertion macros shared by the checker of the frequency-ordered list.
// No dependencies; each macro expects clk in scope, and FOL_ASSERT also rst.
`ifndef FREQUENCY_ORDERED_LIST_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_MACROS_SVH

// Check outside reset.
`define FOL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define FOL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fol_pkg.sv
// Shared types and codes of the frequency-ordered list.
// No dependencies; used by controller, datapath, top level and checker.
package fol_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FIND,
    S_RANK,
    S_MOVE
  } state_t;

  typedef enum logic [1:0] {
    R_LOCATED   = 2'd0,
    R_NOT_FOUND = 2'd1,
    R_APPENDED  = 2'd2,
    R_FULL      = 2'd3
  } result_t;

  typedef struct packed {
    logic load;
    logic find;
    logic rank;
    logic move;
    logic append;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } stat_t;

endpackage

// File: hdl/fol_ctrl.sv
// Sequencer of the frequency-ordered list: steps through append, or find, rank and move.
// Depends on fol_pkg; drives the datapath through cmd_t and owns out_valid.
module fol_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           kind,
  input  logic           out_stall,
  input  fol_pkg::stat_t stat,
  output logic           in_stall,
  output logic           out_valid,
  output fol_pkg::cmd_t  cmd
);
  import fol_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = kind ? S_FIND : S_APPEND;
        end
      end
      S_APPEND: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        state_next = stat.hit ? S_RANK : S_MOVE;
      end
      S_RANK: begin
        state_next = S_MOVE;
      end
      S_MOVE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_APPEND: begin
        cmd.append = out_free;
      end
      S_FIND: begin
        cmd.find = 1'b1;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
      end
      S_MOVE: begin
        cmd.move = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_next = cmd.append || cmd.move || (out_valid && out_stall);
  end

endmodule

// File: hdl/fol_datapath.sv
// Entry row, parallel key compare, rank and shift, and result register.
// Depends on fol_pkg; commanded by fol_ctrl.
module fol_datapath #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  fol_pkg::cmd_t       cmd,
  input  logic signed [31:0]  key,
  output fol_pkg::stat_t      stat,
  output logic [1:0]          status,
  output logic [3:0]          position,
  output logic [15:0]         access_count
);
  import fol_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0]           keys   [ENTRIES];
  logic [COUNT_BITS-1:0] counts [ENTRIES];
  logic [CW-1:0]         used;
  logic [31:0]           key_q;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    gt;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_next;
  logic                  hit;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [IW:0]           dest_wide;
  logic [IW-1:0]         dest;
  logic                  full;
  logic [IW+3:0]         dest_ext;
  logic [CW+3:0]         used_ext;
  logic [COUNT_BITS+15:0] cnt_ext;

  assign stat.hit = |match;
  assign full     = (used == CW'(ENTRIES));
  assign dest_ext = {4'b0, dest};
  assign used_ext = {4'b0, used};
  assign cnt_ext  = {16'b0, cnt};

  always_comb begin
    idx_next = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        idx_next = IW'(k);
      end
    end
    cnt_sel = counts[idx_next];
  end

  always_comb begin
    dest_wide = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (gt[k]) begin
        dest_wide = (IW + 1)'(k + 1);
      end
    end
    dest = dest_wide[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= $unsigned(key);
      for (int k = 0; k < ENTRIES; k++) begin
        match[k] <= (keys[k] == $unsigned(key)) && (CW'(k) < used);
      end
    end
    if (cmd.find) begin
      idx <= idx_next;
      hit <= |match;
      cnt <= (cnt_sel == {COUNT_BITS{1'b1}}) ? cnt_sel : cnt_sel + COUNT_BITS'(1);
    end
    if (cmd.rank) begin
      for (int k = 0; k < ENTRIES; k++) begin
        gt[k] <= (counts[k] > cnt) && (IW'(k) < idx);
      end
    end
    if (cmd.move) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (hit && IW'(k) == dest) begin
          keys[k]   <= key_q;
          counts[k] <= cnt;
        end else if (hit && k > 0 && IW'(k) > dest && IW'(k) <= idx) begin
          keys[k]   <= keys[(k > 0) ? k - 1 : 0];
          counts[k] <= counts[(k > 0) ? k - 1 : 0];
        end
      end
      if (hit) begin
        status       <= R_LOCATED;
        position     <= dest_ext[3:0];
        access_count <= cnt_ext[15:0];
      end else begin
        status       <= R_NOT_FOUND;
        position     <= '0;
        access_count <= '0;
      end
    end
    if (cmd.append) begin
      if (!full) begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (CW'(k) == used) begin
            keys[k]   <= key_q;
            counts[k] <= '0;
          end
        end
        status   <= R_APPENDED;
        position <= used_ext[3:0];
      end else begin
        status   <= R_FULL;
        position <= '0;
      end
      access_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.append && !full) begin
      used <= used + CW'(1);
    end
  end

endmodule

// File: hdl/frequency_ordered_list.sv
// Top level of the frequency-count self-organizing list.
// Depends on fol_pkg, fol_ctrl and fol_datapath.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------
//   input   | in_valid  | in_stall  | kind, key
//   output  | out_valid | out_stall | status, position, access_count
//
// Append captures the key, then writes it; a locate that hits steps through
// capture and compare, find, rank and move, a miss skips rank; one item at a time.
// A result waits in the output register; the next item is accepted meanwhile,
// and its final step holds until out_stall releases the register.
// Reset empties the list at once; entry contents need no clearing.
module frequency_ordered_list #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [3:0]         position,
  output logic [15:0]        access_count
);
  import fol_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fol_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key          (key),
    .stat         (stat),
    .status       (status),
    .position     (position),
    .access_count (access_count)
  );

endmodule

// File: hdl/fol_checker.sv
// Port-level checks of the frequency-ordered list, bound to the top level.
// Depends on fol_pkg and frequency_ordered_list_macros.svh.
`include "frequency_ordered_list_macros.svh"

module fol_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [3:0]         position,
  input logic [15:0]        access_count
);
  import fol_pkg::*;

  `FOL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `FOL_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second item taken while busy")
  `FOL_ASSERT(a_count_zero, out_valid && status != R_LOCATED |-> access_count == 16'd0, "count set on non-locate result")
  `FOL_ASSERT(a_pos_zero, out_valid && (status == R_NOT_FOUND || status == R_FULL) |-> position == 4'd0, "position set on failed result")
  `FOL_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result after reset")

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (.*);
